@@ rtl/cube_face_bilinear_sampler_unit_assert.svh @@
// Assertion macros used by the sampler back end.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CUBE_FACE_BILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define CUBE_FACE_BILINEAR_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define CFBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CFBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cfbs_pkg.sv @@
// Shared types, constants and helpers of the cube face bilinear sampler.
// Used by cfbs_front, cfbs_queue, cfbs_back and the top level.
`timescale 1ns / 1ps
package cfbs_pkg;

  // Parameter defaults
  localparam int unsigned MAX_LOG_SIZE_DEF = 6;
  localparam int unsigned FACE_COUNT_DEF   = 6;

  // Largest supported face size, sizes the address field of a queue word
  localparam int unsigned MAX_LOG_LIMIT = 12;
  localparam int unsigned ADDR_MAX_W =
    $clog2(FACE_COUNT_DEF * (((1 << (2 * MAX_LOG_LIMIT + 2)) - 1) / 3));

  // Texel position is at most 7 bits: the size register is 3 bits wide
  localparam int unsigned POS_W  = 7;
  localparam int unsigned SIDE_W = 8;

  // Decoupling queue depth, a power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic CFG_LOG_BASE_SIZE = 1'b0;
  localparam logic CFG_LEVEL_COUNT   = 1'b1;

  // Register reset values
  localparam logic [2:0] LOG_BASE_SIZE_RST = 3'd6;
  localparam logic [2:0] LEVEL_COUNT_RST   = 3'd7;

  // Function codes of an input word
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Work kinds passed from front to back
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SAMPLE,
    OP_FLAT
  } op_e;

  // Back end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_e;

  // One classified word in the queue
  typedef struct packed {
    op_e                     op;
    logic [ADDR_MAX_W-1:0]   addr;     // write address or top-left texel
    logic                    dx;       // step to the right neighbour
    logic [SIDE_W-1:0]       dy;       // step to the lower neighbour
    logic [7:0]              fx;
    logic [7:0]              fy;
    logic                    at_edge;
    logic                    bad;      // flat result with bad level flag
    logic [7:0]              data;     // texel value for a write
  } entry_t;

  // Start of a level inside a face: the larger levels come first
  function automatic logic [31:0] level_offset(input logic [2:0] level,
                                               input int unsigned max_log);
    logic [31:0] off;
    off = '0;
    for (int unsigned k = 0; k < 7; k++) begin
      if ((32'(k) < 32'(level)) && (k <= max_log)) begin
        off = off + (32'd1 << (2 * (max_log - k)));
      end
    end
    return off;
  endfunction

endpackage

@@ rtl/cfbs_front.sv @@
// Front end: input register, configuration registers and classification.
// Produces cfbs_pkg::entry_t words for the queue; uses cfbs_pkg.
`timescale 1ns / 1ps
module cfbs_front #(
  parameter int unsigned MAX_LOG_SIZE = cfbs_pkg::MAX_LOG_SIZE_DEF,
  parameter int unsigned FACE_COUNT   = cfbs_pkg::FACE_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                func_i,
  input  logic [2:0]          face_i,
  input  logic [2:0]          level_i,
  input  logic [5:0]          tex_x_i,
  input  logic [5:0]          tex_y_i,
  input  logic [7:0]          texel_in_i,
  input  logic [15:0]         coord_u_i,
  input  logic [15:0]         coord_v_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [2:0]          cfg_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cfbs_pkg::entry_t    entry_o
);

  localparam int unsigned FaceWords = ((1 << (2 * MAX_LOG_SIZE + 2)) - 1) / 3;
  localparam logic [2:0] EffCap = (MAX_LOG_SIZE > 7) ? 3'd7 : 3'(MAX_LOG_SIZE);
  localparam int unsigned AW = cfbs_pkg::ADDR_MAX_W;
  localparam int unsigned PW = cfbs_pkg::POS_W;

  logic [2:0]  log_q, count_q;
  logic        f_v_q, f_v_d;
  logic        func_q;
  logic [2:0]  face_q, level_q;
  logic [5:0]  tx_q, ty_q;
  logic [7:0]  data_q;
  logic [15:0] u_q, v_q;

  logic [2:0]        eff;
  logic [2:0]        s;
  logic              face_ok, lev_ok, in_range, drop, accept, leave;
  logic [cfbs_pkg::SIDE_W-1:0] side;
  logic [22:0]       ext_u, ext_v;
  logic [PW-1:0]     px, py, x, y;
  logic [31:0]       off;
  logic [AW-1:0]     addr;
  logic              ex, ey;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_q   <= cfbs_pkg::LOG_BASE_SIZE_RST;
      count_q <= cfbs_pkg::LEVEL_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfbs_pkg::CFG_LOG_BASE_SIZE: log_q   <= cfg_data_i;
        cfbs_pkg::CFG_LEVEL_COUNT:   count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the held word
  always_comb begin
    eff      = (log_q > EffCap) ? EffCap : log_q;
    face_ok  = 32'(face_q) < FACE_COUNT;
    lev_ok   = (level_q < count_q) && (level_q <= eff);
    s        = eff - level_q;
    side     = cfbs_pkg::SIDE_W'(1) << s;
    ext_u    = {7'd0, u_q} << s;
    ext_v    = {7'd0, v_q} << s;
    px       = ext_u[22:16];
    py       = ext_v[22:16];
    ex       = (cfbs_pkg::SIDE_W'(px) + cfbs_pkg::SIDE_W'(1)) == side;
    ey       = (cfbs_pkg::SIDE_W'(py) + cfbs_pkg::SIDE_W'(1)) == side;
    in_range = ((tx_q >> s) == 6'd0) && ((ty_q >> s) == 6'd0);
    x        = (func_q == cfbs_pkg::FUNC_WRITE) ? {1'b0, tx_q} : px;
    y        = (func_q == cfbs_pkg::FUNC_WRITE) ? {1'b0, ty_q} : py;
    off      = cfbs_pkg::level_offset(level_q, MAX_LOG_SIZE);
    addr     = AW'(32'(face_q) * FaceWords) + AW'(off) + (AW'(y) << s) + AW'(x);

    entry_o         = '0;
    entry_o.addr    = addr;
    entry_o.dx      = !ex;
    entry_o.dy      = ey ? '0 : side;
    entry_o.fx      = ext_u[15:8];
    entry_o.fy      = ext_v[15:8];
    entry_o.at_edge = ex || ey;
    entry_o.data    = data_q;
    drop            = 1'b0;
    if (func_q == cfbs_pkg::FUNC_WRITE) begin
      entry_o.op = cfbs_pkg::OP_WRITE;
      drop       = !(face_ok && lev_ok && in_range);
    end else if (!face_ok || !lev_ok) begin
      entry_o.op      = cfbs_pkg::OP_FLAT;
      entry_o.bad     = face_ok;
      entry_o.at_edge = 1'b0;
    end else begin
      entry_o.op = cfbs_pkg::OP_SAMPLE;
    end
  end

  // Hand the word on, or drop an ignored write
  assign leave  = f_v_q && (drop || !q_full_i);
  assign push_o = f_v_q && !drop && !q_full_i;
  assign busy_o = f_v_q && !leave;
  assign accept = start_i && !busy_o;

  always_comb begin
    f_v_d = f_v_q;
    if (leave) begin
      f_v_d = 1'b0;
    end
    if (accept) begin
      f_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      face_q  <= face_i;
      level_q <= level_i;
      tx_q    <= tex_x_i;
      ty_q    <= tex_y_i;
      data_q  <= texel_in_i;
      u_q     <= coord_u_i;
      v_q     <= coord_v_i;
    end
  end

endmodule

@@ rtl/cfbs_queue.sv @@
// Short queue of classified words between front and back end.
// Word type cfbs_pkg::entry_t, depth cfbs_pkg::QUEUE_DEPTH.
`timescale 1ns / 1ps
module cfbs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cfbs_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output cfbs_pkg::entry_t  head_o
);

  localparam int unsigned PtrW = $clog2(cfbs_pkg::QUEUE_DEPTH);

  cfbs_pkg::entry_t entries_q [cfbs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;

  assign full_o  = count_q == (PtrW + 1)'(cfbs_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entries_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
      count_d  = count_d + (PtrW + 1)'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      count_d  = count_d - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/cfbs_back.sv @@
// Back end: texel memory, four-read fetch sequencer and blend accumulator.
// Uses cfbs_pkg and the assertion macros of the sampler.
`timescale 1ns / 1ps
`include "cube_face_bilinear_sampler_unit_assert.svh"
module cfbs_back #(
  parameter int unsigned MAX_LOG_SIZE = cfbs_pkg::MAX_LOG_SIZE_DEF,
  parameter int unsigned FACE_COUNT   = cfbs_pkg::FACE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  cfbs_pkg::entry_t  head_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [7:0]        sample_value_o,
  output logic              at_edge_o,
  output logic              bad_level_o
);

  localparam int unsigned FaceWords  = ((1 << (2 * MAX_LOG_SIZE + 2)) - 1) / 3;
  localparam int unsigned StoreDepth = FACE_COUNT * FaceWords;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned AW         = cfbs_pkg::ADDR_MAX_W;

  logic [7:0]        mem_q [StoreDepth];
  logic [7:0]        rdata_q;
  logic              mem_we;
  logic [AW-1:0]     raddr_full;

  cfbs_pkg::state_e  state_q, state_d;
  logic [1:0]        cnt_q, cnt_d;
  cfbs_pkg::entry_t  cur_q, cur_d;
  logic              can_load;
  logic [8:0]        wa, wb;

  // Blend slot: one texel weight in flight
  logic              p_v_q, p_v_d;
  logic              p_first_q, p_first_d, p_last_q, p_last_d;
  logic              p_flat_q, p_flat_d, p_bad_q, p_bad_d, p_edge_q, p_edge_d;
  logic [16:0]       wt_q, wt_d;

  logic [23:0]       acc_q, acc_d, sum_now;
  logic              done_q, done_d;
  logic [7:0]        value_q, value_d;
  logic              edge_q, edge_d, bad_q, bad_d;

  // Sequence the fetches and take words from the queue
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    p_v_d     = 1'b0;
    p_first_d = 1'b0;
    p_last_d  = 1'b0;
    p_flat_d  = 1'b0;
    p_bad_d   = 1'b0;
    p_edge_d  = cur_q.at_edge;
    wa        = cnt_q[0] ? {1'b0, cur_q.fx} : (9'd256 - {1'b0, cur_q.fx});
    wb        = cnt_q[1] ? {1'b0, cur_q.fy} : (9'd256 - {1'b0, cur_q.fy});
    wt_d      = 17'(wa * wb);
    raddr_full = cur_q.addr + (cnt_q[0] ? AW'(cur_q.dx) : '0)
               + (cnt_q[1] ? AW'(cur_q.dy) : '0);

    can_load = !q_empty_i && ((state_q == cfbs_pkg::ST_IDLE)
             || ((state_q == cfbs_pkg::ST_FETCH) && (cnt_q == 2'd3)
                 && (head_i.op != cfbs_pkg::OP_FLAT)));

    case (state_q)
      cfbs_pkg::ST_FETCH: begin
        p_v_d     = 1'b1;
        p_first_d = cnt_q == 2'd0;
        p_last_d  = cnt_q == 2'd3;
        cnt_d     = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = cfbs_pkg::ST_IDLE;
        end
      end
      default: ;
    endcase

    if (can_load) begin
      pop_o = 1'b1;
      case (head_i.op)
        cfbs_pkg::OP_WRITE: begin
          mem_we = 1'b1;
        end
        cfbs_pkg::OP_SAMPLE: begin
          cur_d   = head_i;
          cnt_d   = 2'd0;
          state_d = cfbs_pkg::ST_FETCH;
        end
        cfbs_pkg::OP_FLAT: begin
          p_v_d     = 1'b1;
          p_first_d = 1'b1;
          p_last_d  = 1'b1;
          p_flat_d  = 1'b1;
          p_bad_d   = head_i.bad;
          p_edge_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfbs_pkg::ST_IDLE;
      cnt_q   <= '0;
      p_v_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      p_v_q   <= p_v_d;
      done_q  <= done_d;
    end
  end

  // Texel memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_i.addr[AddrW-1:0]] <= head_i.data;
    end
    rdata_q <= mem_q[raddr_full[AddrW-1:0]];
  end

  // Accumulate the weighted texels, emit on the last one
  always_comb begin
    sum_now = (p_first_q ? 24'd0 : acc_q) + 24'(rdata_q * wt_q);
    acc_d   = acc_q;
    done_d  = 1'b0;
    value_d = value_q;
    edge_d  = edge_q;
    bad_d   = bad_q;
    if (p_v_q && !p_flat_q) begin
      acc_d = sum_now;
    end
    if (p_v_q && p_last_q) begin
      done_d  = 1'b1;
      value_d = p_flat_q ? 8'd0 : sum_now[23:16];
      edge_d  = p_edge_q;
      bad_d   = p_bad_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    p_first_q <= p_first_d;
    p_last_q  <= p_last_d;
    p_flat_q  <= p_flat_d;
    p_bad_q   <= p_bad_d;
    p_edge_q  <= p_edge_d;
    wt_q      <= wt_d;
    acc_q     <= acc_d;
    value_q   <= value_d;
    edge_q    <= edge_d;
    bad_q     <= bad_d;
  end

  assign done_o         = done_q;
  assign sample_value_o = value_q;
  assign at_edge_o      = edge_q;
  assign bad_level_o    = bad_q;

  `CFBS_ASSERT_NOW(a_pop_only_at_end, (state_q == cfbs_pkg::ST_FETCH) && (cnt_q != 2'd3), !pop_o, "queue popped in the middle of a fetch")
  `CFBS_ASSERT_NEXT(a_last_slot_emits, p_v_q && p_last_q, done_q, "last blend slot gave no result")
  `CFBS_ASSERT_NOW(a_slot_chain, p_v_q && !p_first_q, $past(p_v_q) && !$past(p_last_q), "blend slot without predecessor")
  `CFBS_ASSERT_NOW(a_bad_is_flat, done_q && bad_q, (value_q == 8'd0) && !edge_q, "bad level result not zero")

endmodule

@@ rtl/cube_face_bilinear_sampler_unit.sv @@
// Cube face bilinear sampler: top level joining front end, queue and back end.
// Depends on cfbs_pkg, cfbs_front, cfbs_queue and cfbs_back.
//
// Usage:
//   Input words are taken at a rising edge with start_i high and busy_o low.
//   func_i selects a texel write (face_i, level_i, tex_x_i, tex_y_i,
//   texel_in_i) or a bilinear sample (face_i, level_i, coord_u_i, coord_v_i).
//   Each sample gives one result: done_o is high for one cycle with
//   sample_value_o, at_edge_o and bad_level_o. Writes give no result.
//   The receiver cannot stall; results are never held back.
//   Configuration: cfg_we_i with cfg_idx_i (0 log base size, 1 level count)
//   and cfg_data_i; user writes only while the block is idle (not enforced).
//   A sample result passes the input register, the queue, the four texel
//   reads and the blend slot; a sample with bad face or level skips the reads.
//   The back end reads a sample's four texels, one texel read per cycle, from
//   a texel memory that has a write port apart from its read port.
//   A two-word queue lets the front end accept words while the back end
//   fetches; busy_o rises when the queue and the input register are full.
//   Reset clears the control state and sets the size registers to 6 and 7;
//   the texel memory holds no defined value until written.
`timescale 1ns / 1ps
module cube_face_bilinear_sampler_unit #(
  parameter int unsigned MAX_LOG_SIZE = cfbs_pkg::MAX_LOG_SIZE_DEF,
  parameter int unsigned FACE_COUNT   = cfbs_pkg::FACE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [2:0]  face_i,
  input  logic [2:0]  level_i,
  input  logic [5:0]  tex_x_i,
  input  logic [5:0]  tex_y_i,
  input  logic [7:0]  texel_in_i,
  input  logic [15:0] coord_u_i,
  input  logic [15:0] coord_v_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  output logic        done_o,
  output logic [7:0]  sample_value_o,
  output logic        at_edge_o,
  output logic        bad_level_o
);

  logic             q_full, q_empty, push, pop;
  cfbs_pkg::entry_t push_word, head_word;

  // Accept and classify words
  cfbs_front #(
    .MAX_LOG_SIZE (MAX_LOG_SIZE),
    .FACE_COUNT   (FACE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .face_i     (face_i),
    .level_i    (level_i),
    .tex_x_i    (tex_x_i),
    .tex_y_i    (tex_y_i),
    .texel_in_i (texel_in_i),
    .coord_u_i  (coord_u_i),
    .coord_v_i  (coord_v_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_word)
  );

  // Decouple front and back
  cfbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_word),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_word)
  );

  // Fetch, blend and emit
  cfbs_back #(
    .MAX_LOG_SIZE (MAX_LOG_SIZE),
    .FACE_COUNT   (FACE_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .head_i         (head_word),
    .pop_o          (pop),
    .done_o         (done_o),
    .sample_value_o (sample_value_o),
    .at_edge_o      (at_edge_o),
    .bad_level_o    (bad_level_o)
  );

endmodule

@@ tb/cfbs_sample_checker.sv @@
// Scoreboard side of the sampler testbench: a small helper package with the
// texel layout, and a checker that mirrors the texture and compares results.
// Depends on cfbs_pkg for function codes, register indexes and reset values.
`timescale 1ns / 1ps
package cfbs_tb_pkg;

  localparam int unsigned MAX_LOG   = 6;
  localparam int unsigned FACES     = 6;
  localparam int unsigned FACE_SPAN = ((1 << (2 * MAX_LOG + 2)) - 1) / 3;
  localparam int unsigned TEXELS    = FACES * FACE_SPAN;

  // Sizes above the supported maximum act as the maximum
  function automatic int unsigned clamp_log(input logic [2:0] log_size);
    return (log_size > MAX_LOG) ? MAX_LOG : int'(log_size);
  endfunction

  function automatic bit level_usable(input logic [2:0] level, input logic [2:0] log_size,
                                      input logic [2:0] count);
    return (level < count) && (level <= clamp_log(log_size));
  endfunction

  // Store address of texel (x, y): inside a face the larger levels come first
  function automatic int unsigned texel_addr(input int unsigned face, input int unsigned level,
                                             input int unsigned side, input int unsigned x,
                                             input int unsigned y);
    int unsigned full;
    full = 1 << (2 * MAX_LOG + 2);
    return face * FACE_SPAN + (full - (full >> (2 * level))) / 3 + x + y * side;
  endfunction

endpackage

module cfbs_sample_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        func_i,
  input  logic [2:0]  face_i,
  input  logic [2:0]  level_i,
  input  logic [5:0]  tex_x_i,
  input  logic [5:0]  tex_y_i,
  input  logic [7:0]  texel_in_i,
  input  logic [15:0] coord_u_i,
  input  logic [15:0] coord_v_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        done_i,
  input  logic [7:0]  sample_value_i,
  input  logic        at_edge_i,
  input  logic        bad_level_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import cfbs_pkg::*;
  import cfbs_tb_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       at_edge;
    logic       bad_level;
  } sample_t;

  logic [7:0]  texels [TEXELS];
  logic [2:0]  log_size_q;
  logic [2:0]  level_count_q;
  sample_t     awaited_samples [$];
  int unsigned fails;

  // Blend the four texels around (u, v) with weights from 8-bit fractions
  function automatic sample_t blend_sample(input logic [2:0] face, input logic [2:0] level,
                                           input logic [15:0] u, input logic [15:0] v);
    sample_t     r;
    int unsigned s, side, base, px, py, fx, fy, nx, ny, sum;
    bit          ex, ey;
    r = '0;
    if (face >= FACES) return r;
    if (!level_usable(level, log_size_q, level_count_q)) begin
      r.bad_level = 1'b1;
      return r;
    end
    s    = clamp_log(log_size_q) - level;
    side = 1 << s;
    base = texel_addr(face, level, side, 0, 0);
    px   = int'(u) >> (16 - s);
    py   = int'(v) >> (16 - s);
    fx   = ((int'(u) << s) & 32'hFFFF) >> 8;
    fy   = ((int'(v) << s) & 32'hFFFF) >> 8;
    // Clamp the right and lower neighbours at the edge
    ex   = (px + 1 >= side);
    ey   = (py + 1 >= side);
    nx   = ex ? px : px + 1;
    ny   = ey ? py : py + 1;
    sum  = int'(texels[base + px + py * side]) * ((256 - fx) * (256 - fy))
         + int'(texels[base + nx + py * side]) * (fx * (256 - fy))
         + int'(texels[base + px + ny * side]) * ((256 - fx) * fy)
         + int'(texels[base + nx + ny * side]) * (fx * fy);
    r.value   = 8'(sum >> 16);
    r.at_edge = ex || ey;
    return r;
  endfunction

  // Drop writes to a bad face, a bad level or outside the level
  function automatic void store_texel(input logic [2:0] face, input logic [2:0] level,
                                      input logic [5:0] x, input logic [5:0] y,
                                      input logic [7:0] val);
    int unsigned side;
    if (face >= FACES || !level_usable(level, log_size_q, level_count_q)) return;
    side = 1 << (clamp_log(log_size_q) - level);
    if (x < side && y < side) texels[texel_addr(face, level, side, x, y)] = val;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      log_size_q    = LOG_BASE_SIZE_RST;
      level_count_q = LEVEL_COUNT_RST;
      fails         = 0;
      awaited_samples.delete();
    end else begin
      // Check a result word against the oldest awaited sample
      if (done_i) begin
        if (awaited_samples.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, got value %0d at_edge %0b bad_level %0b",
                   $time, sample_value_i, at_edge_i, bad_level_i);
        end else begin
          want = awaited_samples.pop_front();
          compare_field("sample_value", want.value, sample_value_i);
          compare_field("at_edge", 8'(want.at_edge), 8'(at_edge_i));
          compare_field("bad_level", 8'(want.bad_level), 8'(bad_level_i));
        end
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOG_BASE_SIZE: log_size_q = cfg_data_i;
          CFG_LEVEL_COUNT:   level_count_q = cfg_data_i;
          default: ;
        endcase
      end
      // Apply an accepted input word
      if (start_i && !busy_i) begin
        if (func_i == FUNC_SAMPLE) begin
          awaited_samples.push_back(blend_sample(face_i, level_i, coord_u_i, coord_v_i));
        end else begin
          store_texel(face_i, level_i, tex_x_i, tex_y_i, texel_in_i);
        end
      end
    end
    pending_o    <= awaited_samples.size();
    fail_count_o <= fails;
  end

endmodule

@@ tb/cube_face_bilinear_sampler_unit_tb.sv @@
// Top of the sampler testbench: clock, reset, stimulus and verdict.
// Depends on cfbs_pkg, cfbs_tb_pkg and cfbs_sample_checker.
`timescale 1ns / 1ps
module cube_face_bilinear_sampler_unit_tb;
  import cfbs_pkg::*;
  import cfbs_tb_pkg::*;

  localparam int unsigned ACTIONS_PER_PHASE = 90;
  localparam int unsigned PHASES            = 8;
  localparam int unsigned DRAIN_CYCLES      = 16;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        func;
  logic [2:0]  face;
  logic [2:0]  level;
  logic [5:0]  tex_x;
  logic [5:0]  tex_y;
  logic [7:0]  texel_in;
  logic [15:0] coord_u;
  logic [15:0] coord_v;
  logic        cfg_we;
  logic        cfg_idx;
  logic [2:0]  cfg_data;
  logic        done;
  logic [7:0]  sample_value;
  logic        at_edge;
  logic        bad_level;
  int unsigned pending;
  int unsigned fail_count;

  // Stimulus-side view of the configuration and of the texels written so far
  logic [2:0]  cur_log;
  logic [2:0]  cur_count;
  bit          texel_written [TEXELS];
  bit          idle_on;
  int unsigned writes_sent, samples_sent, edge_seen, bad_seen;

  cube_face_bilinear_sampler_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .func_i         (func),
    .face_i         (face),
    .level_i        (level),
    .tex_x_i        (tex_x),
    .tex_y_i        (tex_y),
    .texel_in_i     (texel_in),
    .coord_u_i      (coord_u),
    .coord_v_i      (coord_v),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_o         (done),
    .sample_value_o (sample_value),
    .at_edge_o      (at_edge),
    .bad_level_o    (bad_level)
  );

  cfbs_sample_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func),
    .face_i         (face),
    .level_i        (level),
    .tex_x_i        (tex_x),
    .tex_y_i        (tex_y),
    .texel_in_i     (texel_in),
    .coord_u_i      (coord_u),
    .coord_v_i      (coord_v),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_i         (done),
    .sample_value_i (sample_value),
    .at_edge_i      (at_edge),
    .bad_level_i    (bad_level),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count result kinds for the summary
  always @(posedge clk) begin
    if (done && at_edge) edge_seen++;
    if (done && bad_level) bad_seen++;
  end

  // Drive one word and hold it until accepted, with an optional idle burst first
  task automatic send_word(input logic fn, input logic [2:0] fc, input logic [2:0] lv,
                           input logic [5:0] x, input logic [5:0] y, input logic [7:0] val,
                           input logic [15:0] u, input logic [15:0] v);
    int unsigned gap, side;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    func     <= fn;
    face     <= fc;
    level    <= lv;
    tex_x    <= x;
    tex_y    <= y;
    texel_in <= val;
    coord_u  <= u;
    coord_v  <= v;
    do @(posedge clk); while (busy);
    if (fn == FUNC_SAMPLE) begin
      samples_sent++;
    end else begin
      writes_sent++;
      if (fc < FACES && level_usable(lv, cur_log, cur_count)) begin
        side = 1 << (clamp_log(cur_log) - lv);
        if (x < side && y < side) texel_written[texel_addr(fc, lv, side, x, y)] = 1'b1;
      end
    end
  endtask

  // Write any of the four neighbours not yet written, then sample
  task automatic fill_then_sample(input logic [2:0] fc, input logic [2:0] lv,
                                  input logic [15:0] u, input logic [15:0] v);
    int unsigned s, side, xs [2], ys [2];
    if (fc < FACES && level_usable(lv, cur_log, cur_count)) begin
      s     = clamp_log(cur_log) - lv;
      side  = 1 << s;
      xs[0] = int'(u) >> (16 - s);
      ys[0] = int'(v) >> (16 - s);
      xs[1] = (xs[0] + 1 >= side) ? xs[0] : xs[0] + 1;
      ys[1] = (ys[0] + 1 >= side) ? ys[0] : ys[0] + 1;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (!texel_written[texel_addr(fc, lv, side, xs[i], ys[j])]) begin
            send_word(FUNC_WRITE, fc, lv, 6'(xs[i]), 6'(ys[j]), 8'($urandom),
                      16'($urandom), 16'($urandom));
          end
        end
      end
    end
    send_word(FUNC_SAMPLE, fc, lv, 6'($urandom), 6'($urandom), 8'($urandom), u, v);
  endtask

  // Hold start low until every result is back, then let queued writes finish
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] log_size, input logic [2:0] count);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LOG_BASE_SIZE;
    cfg_data <= log_size;
    @(negedge clk);
    cfg_idx  <= CFG_LEVEL_COUNT;
    cfg_data <= count;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_log   = log_size;
    cur_count = count;
  endtask

  // Favor small levels so samples reuse texels; sometimes any level
  function automatic logic [2:0] pick_level();
    int unsigned top;
    if (cur_count == 0 || $urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    top = clamp_log(cur_log);
    if (cur_count - 1 < top) top = cur_count - 1;
    return 3'(top - $urandom_range(0, (top < 3) ? top : 3));
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One random step: mostly valid samples and writes, some noise
  task automatic random_action();
    int unsigned pick, side;
    logic [2:0]  fc, lv;
    pick = $urandom_range(0, 99);
    fc   = 3'($urandom_range(0, FACES - 1));
    lv   = pick_level();
    if (pick < 50) begin
      fill_then_sample(fc, lv, pick_frac(), pick_frac());
    end else if (pick < 85) begin
      side = (lv <= clamp_log(cur_log)) ? (1 << (clamp_log(cur_log) - lv)) : 1;
      send_word(FUNC_WRITE, fc, lv, 6'($urandom_range(0, side - 1)),
                6'($urandom_range(0, side - 1)), 8'($urandom), 16'($urandom), 16'($urandom));
    end else if ($urandom_range(0, 1) == 0) begin
      fill_then_sample(3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_word(FUNC_WRITE, 3'($urandom), 3'($urandom), 6'($urandom), 6'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [2:0] phase_log   [PHASES];
    logic [2:0] phase_count [PHASES];
    phase_log   = '{3'd6, 3'd0, 3'd3, 3'd7, 3'd2, 3'd1, 3'd6, 3'd4};
    phase_count = '{3'd7, 3'd1, 3'd4, 3'd7, 3'd0, 3'd7, 3'd2, 3'd6};
    rst_n     = 1'b0;
    start     = 1'b0;
    func      = FUNC_WRITE;
    face      = '0;
    level     = '0;
    tex_x     = '0;
    tex_y     = '0;
    texel_in  = '0;
    coord_u   = '0;
    coord_v   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_LOG_BASE_SIZE;
    cfg_data  = '0;
    cur_log   = LOG_BASE_SIZE_RST;
    cur_count = LEVEL_COUNT_RST;
    idle_on   = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: corner texels, half-way blend, both edges, bad level and bad face
    send_word(FUNC_WRITE, 3'd0, 3'd0, 6'd0, 6'd0, 8'hFF, 16'h0000, 16'h0000);
    send_word(FUNC_WRITE, 3'd0, 3'd0, 6'd1, 6'd0, 8'h00, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_WRITE, 3'd0, 3'd0, 6'd0, 6'd1, 8'h00, 16'h0000, 16'h0000);
    send_word(FUNC_WRITE, 3'd0, 3'd0, 6'd1, 6'd1, 8'hFF, 16'hFFFF, 16'hFFFF);
    fill_then_sample(3'd0, 3'd0, 16'h0000, 16'h0000);
    fill_then_sample(3'd0, 3'd0, 16'h0200, 16'h0200);
    send_word(FUNC_WRITE, 3'd5, 3'd0, 6'd63, 6'd63, 8'hFF, 16'h0000, 16'h0000);
    fill_then_sample(3'd5, 3'd0, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_WRITE, 3'd0, 3'd6, 6'd0, 6'd0, 8'd200, 16'h0000, 16'h0000);
    fill_then_sample(3'd0, 3'd6, 16'h1234, 16'hFEDC);
    fill_then_sample(3'd0, 3'd7, 16'h8000, 16'h8000);
    send_word(FUNC_WRITE, 3'd0, 3'd7, 6'd0, 6'd0, 8'h55, 16'h0000, 16'h0000);
    fill_then_sample(3'd6, 3'd0, 16'h4000, 16'h4000);
    fill_then_sample(3'd7, 3'd3, 16'hFFFF, 16'h0000);
    send_word(FUNC_WRITE, 3'd7, 3'd0, 6'd3, 6'd3, 8'hAA, 16'h0000, 16'h0000);
    send_word(FUNC_WRITE, 3'd1, 3'd3, 6'd63, 6'd5, 8'h11, 16'h0000, 16'h0000);
    send_word(FUNC_WRITE, 3'd1, 3'd3, 6'd5, 6'd63, 8'h22, 16'h0000, 16'h0000);
    fill_then_sample(3'd1, 3'd3, 16'hFFFF, 16'h0000);
    fill_then_sample(3'd2, 3'd1, 16'h0000, 16'hFFFF);

    // Random phases, each under its own register setting; the last one runs flat out
    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_log[p], phase_count[p]);
      for (int a = 0; a < ACTIONS_PER_PHASE; a++) begin
        if (a % 30 == 0) idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        random_action();
      end
    end
    drain();

    $display("Covered %0d texel writes and %0d samples over %0d register settings,",
             writes_sent, samples_sent, PHASES + 1);
    $display("with %0d edge-clamped and %0d bad-level results.", edge_seen, bad_seen);
    if (fail_count == 0) begin
      $display("cube_face_bilinear_sampler_unit: match");
    end else begin
      $display("cube_face_bilinear_sampler_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Timeout with %0d results still expected", pending);
    $display("cube_face_bilinear_sampler_unit: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cfbs_pkg.sv
rtl/cfbs_front.sv
rtl/cfbs_queue.sv
rtl/cfbs_back.sv
rtl/cube_face_bilinear_sampler_unit.sv
tb/cfbs_sample_checker.sv
tb/cube_face_bilinear_sampler_unit_tb.sv
